>>> rtl/yuvrgb_pkg.sv
`timescale 1ns / 1ps

package yuvrgb_pkg;

   typedef struct packed {
      logic [7:0] luma_first;
      logic [7:0] luma_second;
      logic [7:0] chroma_blue;
      logic [7:0] chroma_red;
   } req_type;

   typedef struct packed {
      logic [7:0] red_first;
      logic [7:0] green_first;
      logic [7:0] blue_first;
      logic [7:0] red_second;
      logic [7:0] green_second;
      logic [7:0] blue_second;
   } rsp_type;

   typedef enum logic {
      MODE_PACKED = 1'b0,
      MODE_PLANAR = 1'b1
   } mode_type;

   localparam logic [7:0] CHROMA_OFFSET = 8'd128;

   // packed path, Q8 coefficients
   localparam logic signed [16:0] COEF_CB = 17'sd454;
   localparam logic signed [16:0] COEF_CG_U = 17'sd88;
   localparam logic signed [16:0] COEF_CG_V = 17'sd183;
   localparam logic signed [16:0] COEF_CR = 17'sd359;

   // planar path, per mille coefficients on chroma magnitude
   localparam logic [15:0] COEF_U_MILLI = 16'd354;
   localparam logic [16:0] COEF_V_MILLI = 17'd707;

   // x / 1000 == (x * RECIP_1000) >> RECIP_SHIFT, exact for x < 2^17
   localparam int RECIP_SHIFT = 26;
   localparam logic [16:0] RECIP_1000 = 17'd67109;

   function automatic logic [7:0] clamp_channel(input logic signed [9:0] sum);
      logic [7:0] res;
      if (sum[9]) begin
         res = 8'd0;
      end else if (sum[8]) begin
         res = 8'd255;
      end else begin
         res = sum[7:0];
      end
      return res;
   endfunction

endpackage

>>> rtl/yuv_pair_to_rgb_converter_core.sv
`timescale 1ns / 1ps

// channel | ports                              | handshake
// --------+------------------------------------+---------------------------------
// request | start, busy, req_data              | beat when start && !busy
// result  | rsp_valid, rsp_data                | one-cycle strobe, no back-pressure
// csr     | csr_valid, csr_ready, csr_data     | beat when csr_valid && csr_ready
//
// Five register stages: chroma offset, coefficient multiply, scale (shift or
// reciprocal multiply for /1000), chroma terms, luma add with clamp.
// One beat per clock; valid runs v1_ff, v2_ff, v3_ff, v4_ff to rsp_valid_ff.
// busy and csr_ready are constant, so nothing ever stalls.
// Synchronous active-high reset clears the valid bits and the mode register.
// The mode is sampled with each request beat and travels down the pipe.

module yuv_pair_to_rgb_converter_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  yuvrgb_pkg::req_type  req_data,
   output logic                 rsp_valid,
   output yuvrgb_pkg::rsp_type  rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic                 csr_data
);

   logic accept;

   yuvrgb_pkg::mode_type mode_ff, mode_in;

   // stage 1
   logic v1_ff;
   yuvrgb_pkg::mode_type mode1_ff;
   logic [7:0] y0_1_ff, y1_1_ff;
   logic signed [8:0] du1_ff, dv1_ff, du1_in, dv1_in;

   // stage 2
   logic v2_ff;
   yuvrgb_pkg::mode_type mode2_ff;
   logic [7:0] y0_2_ff, y1_2_ff;
   logic signed [16:0] pb2_ff, pg2_ff, pr2_ff, pb2_in, pg2_in, pr2_in;
   logic [15:0] um2_ff, um2_in;
   logic [16:0] vm2_ff, vm2_in;
   logic us2_ff, vs2_ff;
   logic signed [16:0] du_ext, dv_ext;
   logic [7:0] du_abs, dv_abs;

   // stage 3
   logic v3_ff;
   yuvrgb_pkg::mode_type mode3_ff;
   logic [7:0] y0_3_ff, y1_3_ff;
   logic signed [8:0] cb3_ff, cg3_ff, cr3_ff;
   logic [32:0] up3_ff, up3_in;
   logic [33:0] vp3_ff, vp3_in;
   logic us3_ff, vs3_ff;

   // stage 4
   logic v4_ff;
   yuvrgb_pkg::mode_type mode4_ff;
   logic [7:0] y0_4_ff, y1_4_ff;
   logic signed [8:0] add_r4_ff, sub_g4_ff, add_b4_ff;
   logic signed [8:0] add_r4_in, sub_g4_in, add_b4_in;
   logic [5:0] uq_mag;
   logic [6:0] vq_mag;
   logic signed [8:0] uq_s, vq_s;

   // stage 5
   logic rsp_valid_ff;
   yuvrgb_pkg::rsp_type rsp_ff, rsp_in;
   logic signed [9:0] r0_sum, g0_sum, b0_sum, r1_sum, g1_sum, b1_sum;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   assign mode_in = (csr_valid && csr_ready) ? yuvrgb_pkg::mode_type'(csr_data) : mode_ff;

   // stage 1: remove chroma offset
   assign du1_in = $signed({1'b0, req_data.chroma_blue}) -
                   $signed({1'b0, yuvrgb_pkg::CHROMA_OFFSET});
   assign dv1_in = $signed({1'b0, req_data.chroma_red}) -
                   $signed({1'b0, yuvrgb_pkg::CHROMA_OFFSET});

   // stage 2: products
   assign du_ext = 17'(du1_ff);
   assign dv_ext = 17'(dv1_ff);
   assign du_abs = du1_ff[8] ? 8'(-du1_ff) : du1_ff[7:0];
   assign dv_abs = dv1_ff[8] ? 8'(-dv1_ff) : dv1_ff[7:0];
   assign pb2_in = du_ext * yuvrgb_pkg::COEF_CB;
   assign pg2_in = du_ext * yuvrgb_pkg::COEF_CG_U + dv_ext * yuvrgb_pkg::COEF_CG_V;
   assign pr2_in = dv_ext * yuvrgb_pkg::COEF_CR;
   assign um2_in = 16'(du_abs) * yuvrgb_pkg::COEF_U_MILLI;
   assign vm2_in = 17'(dv_abs) * yuvrgb_pkg::COEF_V_MILLI;

   // stage 3: reciprocal multiply for the /1000 path
   assign up3_in = 33'(um2_ff) * 33'(yuvrgb_pkg::RECIP_1000);
   assign vp3_in = 34'(vm2_ff) * 34'(yuvrgb_pkg::RECIP_1000);

   // stage 4: chroma terms, truncation toward zero via sign-magnitude
   assign uq_mag = up3_ff[yuvrgb_pkg::RECIP_SHIFT +: 6];
   assign vq_mag = vp3_ff[yuvrgb_pkg::RECIP_SHIFT +: 7];
   assign uq_s   = us3_ff ? -$signed({3'b000, uq_mag}) : $signed({3'b000, uq_mag});
   assign vq_s   = vs3_ff ? -$signed({2'b00, vq_mag}) : $signed({2'b00, vq_mag});

   always_comb begin
      case (mode3_ff)
         yuvrgb_pkg::MODE_PACKED: begin
            add_r4_in = cr3_ff;
            sub_g4_in = cg3_ff;
            add_b4_in = cb3_ff;
         end
         yuvrgb_pkg::MODE_PLANAR: begin
            add_r4_in = vq_s <<< 1;
            sub_g4_in = uq_s + vq_s;
            add_b4_in = (uq_s <<< 2) + uq_s;
         end
         default: begin
            add_r4_in = cr3_ff;
            sub_g4_in = cg3_ff;
            add_b4_in = cb3_ff;
         end
      endcase
   end

   // stage 5: luma add and clamp
   assign r0_sum = $signed({2'b00, y0_4_ff}) + 10'(add_r4_ff);
   assign g0_sum = $signed({2'b00, y0_4_ff}) - 10'(sub_g4_ff);
   assign b0_sum = $signed({2'b00, y0_4_ff}) + 10'(add_b4_ff);
   assign r1_sum = $signed({2'b00, y1_4_ff}) + 10'(add_r4_ff);
   assign g1_sum = $signed({2'b00, y1_4_ff}) - 10'(sub_g4_ff);
   assign b1_sum = $signed({2'b00, y1_4_ff}) + 10'(add_b4_ff);

   always_comb begin
      rsp_in.red_first    = yuvrgb_pkg::clamp_channel(r0_sum);
      rsp_in.green_first  = yuvrgb_pkg::clamp_channel(g0_sum);
      rsp_in.blue_first   = yuvrgb_pkg::clamp_channel(b0_sum);
      rsp_in.red_second   = yuvrgb_pkg::clamp_channel(r1_sum);
      rsp_in.green_second = yuvrgb_pkg::clamp_channel(g1_sum);
      rsp_in.blue_second  = yuvrgb_pkg::clamp_channel(b1_sum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= yuvrgb_pkg::MODE_PACKED;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mode_ff      <= mode_in;
         v1_ff        <= accept;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         rsp_valid_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      mode1_ff <= mode_ff;
      y0_1_ff  <= req_data.luma_first;
      y1_1_ff  <= req_data.luma_second;
      du1_ff   <= du1_in;
      dv1_ff   <= dv1_in;

      mode2_ff <= mode1_ff;
      y0_2_ff  <= y0_1_ff;
      y1_2_ff  <= y1_1_ff;
      pb2_ff   <= pb2_in;
      pg2_ff   <= pg2_in;
      pr2_ff   <= pr2_in;
      um2_ff   <= um2_in;
      vm2_ff   <= vm2_in;
      us2_ff   <= du1_ff[8];
      vs2_ff   <= dv1_ff[8];

      mode3_ff <= mode2_ff;
      y0_3_ff  <= y0_2_ff;
      y1_3_ff  <= y1_2_ff;
      // floor(x / 256) is the arithmetic shift
      cb3_ff   <= pb2_ff[16:8];
      cg3_ff   <= pg2_ff[16:8];
      cr3_ff   <= pr2_ff[16:8];
      up3_ff   <= up3_in;
      vp3_ff   <= vp3_in;
      us3_ff   <= us2_ff;
      vs3_ff   <= vs2_ff;

      mode4_ff  <= mode3_ff;
      y0_4_ff   <= y0_3_ff;
      y1_4_ff   <= y1_3_ff;
      add_r4_ff <= add_r4_in;
      sub_g4_ff <= sub_g4_in;
      add_b4_ff <= add_b4_in;

      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##5 rsp_valid)
      else $error("request beat without result five cycles later");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(accept, 5))
      else $error("result strobe without matching request beat");

   a_planar_red_even: assert property (@(posedge clock) disable iff (reset)
      (v4_ff && mode4_ff == yuvrgb_pkg::MODE_PLANAR) |-> !add_r4_ff[0])
      else $error("planar red chroma term must be even");

endmodule

>>> test/yuv_pair_to_rgb_converter_core_tb.sv
`timescale 1ns / 1ps

module yuv_pair_to_rgb_converter_core_tb;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 8;
   localparam int PHASE_ITEMS = 220;
   localparam int TAIL_ITEMS = 120;
   localparam int SETTLE_CYCLES = 16;
   localparam int TIMEOUT_NS = 2_000_000;

   localparam int CHROMA_BIAS = 128;
   localparam int Q8_SHIFT = 8;
   localparam int PACKED_CB = 454;
   localparam int PACKED_CG_U = 88;
   localparam int PACKED_CG_V = 183;
   localparam int PACKED_CR = 359;
   localparam int PLANAR_U_MILLI = 354;
   localparam int PLANAR_V_MILLI = 707;
   localparam int MILLI = 1000;

   typedef enum {
      FEED_PIXELS,
      FEED_MODE,
      FEED_DRAIN
   } feed_kind_type;

   typedef struct {
      feed_kind_type        kind;
      yuvrgb_pkg::req_type  pixels;
      yuvrgb_pkg::mode_type mode;
   } feed_entry_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   yuvrgb_pkg::req_type req_data = '0;
   logic                rsp_valid;
   yuvrgb_pkg::rsp_type rsp_data;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic                csr_data = 1'b0;

   feed_entry_type       pixel_feed[$];
   yuvrgb_pkg::rsp_type  rgb_expected[$];
   yuvrgb_pkg::mode_type mode_shadow = yuvrgb_pkg::MODE_PACKED;
   int                   mismatches = 0;
   int                   idle_left = 0;

   logic                next_start;
   logic                next_csr_valid;
   logic                next_csr_data;
   yuvrgb_pkg::req_type next_req;

   yuv_pair_to_rgb_converter_core DUT (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   always #HALF_PERIOD clock = ~clock;

   function automatic logic [7:0] clamp_to_byte(input int v);
      logic [7:0] res;
      if (v < 0) begin
         res = 8'd0;
      end else if (v > 255) begin
         res = 8'd255;
      end else begin
         res = v[7:0];
      end
      return res;
   endfunction

   function automatic yuvrgb_pkg::rsp_type yuv_pair_to_rgb(input yuvrgb_pkg::req_type px,
                                                           input yuvrgb_pkg::mode_type mode);
      int du;
      int dv;
      int uq;
      int vq;
      int add_r;
      int sub_g;
      int add_b;
      int y0;
      int y1;
      yuvrgb_pkg::rsp_type rgb;
      du = int'(px.chroma_blue) - CHROMA_BIAS;
      dv = int'(px.chroma_red) - CHROMA_BIAS;
      y0 = int'(px.luma_first);
      y1 = int'(px.luma_second);
      if (mode == yuvrgb_pkg::MODE_PACKED) begin
         // floor division: arithmetic shift of a signed int
         add_b = (du * PACKED_CB) >>> Q8_SHIFT;
         sub_g = (du * PACKED_CG_U + dv * PACKED_CG_V) >>> Q8_SHIFT;
         add_r = (dv * PACKED_CR) >>> Q8_SHIFT;
      end else begin
         // int division truncates toward zero
         uq = (du * PLANAR_U_MILLI) / MILLI;
         vq = (dv * PLANAR_V_MILLI) / MILLI;
         add_r = 2 * vq;
         sub_g = uq + vq;
         add_b = 5 * uq;
      end
      rgb.red_first = clamp_to_byte(y0 + add_r);
      rgb.green_first = clamp_to_byte(y0 - sub_g);
      rgb.blue_first = clamp_to_byte(y0 + add_b);
      rgb.red_second = clamp_to_byte(y1 + add_r);
      rgb.green_second = clamp_to_byte(y1 - sub_g);
      rgb.blue_second = clamp_to_byte(y1 + add_b);
      return rgb;
   endfunction

   function automatic logic [7:0] pick_extreme();
      logic [7:0] choices [7];
      choices = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
      return choices[$urandom_range(0, 6)];
   endfunction

   function automatic yuvrgb_pkg::req_type random_pixels();
      yuvrgb_pkg::req_type px;
      px = yuvrgb_pkg::req_type'($urandom);
      case ($urandom_range(0, 9))
         5, 6: begin
            // chroma near neutral, where floor and truncation part ways
            px.chroma_blue = 8'(122 + $urandom_range(0, 12));
            px.chroma_red = 8'(122 + $urandom_range(0, 12));
         end
         7: begin
            px.luma_first = pick_extreme();
            px.luma_second = pick_extreme();
            px.chroma_blue = pick_extreme();
            px.chroma_red = pick_extreme();
         end
         8, 9: begin
            px.luma_first = pick_extreme();
            px.luma_second = pick_extreme();
         end
         default: begin
         end
      endcase
      return px;
   endfunction

   task automatic push_pixels(input yuvrgb_pkg::req_type px);
      feed_entry_type e;
      e.kind = FEED_PIXELS;
      e.pixels = px;
      e.mode = yuvrgb_pkg::MODE_PACKED;
      pixel_feed.push_back(e);
   endtask

   task automatic push_control(input feed_kind_type kind, input yuvrgb_pkg::mode_type mode);
      feed_entry_type e;
      e.kind = kind;
      e.pixels = '0;
      e.mode = mode;
      pixel_feed.push_back(e);
   endtask

   task automatic check_channel(input string field, input logic [7:0] want,
                                input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", field, want, got);
         mismatches++;
      end
   endtask

   // driver
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         csr_valid <= 1'b0;
         idle_left = 0;
      end else begin
         next_start = start;
         next_req = req_data;
         next_csr_valid = csr_valid;
         next_csr_data = csr_data;
         if (start && !busy) begin
            next_start = 1'b0;
         end
         if (csr_valid && csr_ready) begin
            next_csr_valid = 1'b0;
         end
         if (!next_start && !next_csr_valid) begin
            if (idle_left > 0) begin
               idle_left--;
            end else if (pixel_feed.size() > 0) begin
               case (pixel_feed[0].kind)
                  FEED_PIXELS: begin
                     if (pixel_feed.size() > TAIL_ITEMS && $urandom_range(0, 9) == 0) begin
                        idle_left = $urandom_range(0, 15);
                     end else begin
                        next_start = 1'b1;
                        next_req = pixel_feed[0].pixels;
                        void'(pixel_feed.pop_front());
                     end
                  end
                  FEED_MODE: begin
                     // only once no beat lands this edge and the pipe is empty
                     if (!start && rgb_expected.size() == 0) begin
                        next_csr_valid = 1'b1;
                        next_csr_data = logic'(pixel_feed[0].mode);
                        void'(pixel_feed.pop_front());
                     end
                  end
                  FEED_DRAIN: begin
                     if (!start && rgb_expected.size() == 0) begin
                        void'(pixel_feed.pop_front());
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         start <= next_start;
         req_data <= next_req;
         csr_valid <= next_csr_valid;
         csr_data <= next_csr_data;
      end
   end

   // monitor: predict on each request beat, check each result strobe
   always @(posedge clock) begin
      yuvrgb_pkg::rsp_type want;
      if (reset) begin
         mode_shadow = yuvrgb_pkg::MODE_PACKED;
      end else begin
         if (start && !busy) begin
            rgb_expected.push_back(yuv_pair_to_rgb(req_data, mode_shadow));
         end
         if (csr_valid && csr_ready) begin
            mode_shadow = yuvrgb_pkg::mode_type'(csr_data);
         end
         if (rsp_valid !== 1'b0) begin
            if (rgb_expected.size() == 0) begin
               $error("unexpected result beat: %h", rsp_data);
               mismatches++;
            end else begin
               want = rgb_expected.pop_front();
               check_channel("red_first", want.red_first, rsp_data.red_first);
               check_channel("green_first", want.green_first, rsp_data.green_first);
               check_channel("blue_first", want.blue_first, rsp_data.blue_first);
               check_channel("red_second", want.red_second, rsp_data.red_second);
               check_channel("green_second", want.green_second, rsp_data.green_second);
               check_channel("blue_second", want.blue_second, rsp_data.blue_second);
            end
         end
      end
   end

   initial begin
      // luma_first, luma_second, chroma_blue, chroma_red
      logic [31:0] directed [12];
      yuvrgb_pkg::mode_type phase_modes [6];
      yuvrgb_pkg::req_type px;
      yuvrgb_pkg::req_type twin;
      int count;
      directed = '{
         32'h00FF8080, 32'hFF000000, 32'h00FFFFFF, 32'h00FF00FF,
         32'hFF00FF00, 32'h80808000, 32'h808080FF, 32'h80800080,
         32'h8080FF80, 32'h10EB7F81, 32'hEB10817F, 32'h01FE40C0
      };
      phase_modes = '{yuvrgb_pkg::MODE_PLANAR, yuvrgb_pkg::MODE_PACKED,
                      yuvrgb_pkg::MODE_PLANAR, yuvrgb_pkg::MODE_PACKED,
                      yuvrgb_pkg::MODE_PACKED, yuvrgb_pkg::MODE_PLANAR};

      // mode is packed out of reset
      foreach (directed[i]) push_pixels(yuvrgb_pkg::req_type'(directed[i]));
      push_control(FEED_MODE, yuvrgb_pkg::MODE_PLANAR);
      foreach (directed[i]) push_pixels(yuvrgb_pkg::req_type'(directed[i]));

      foreach (phase_modes[p]) begin
         push_control(FEED_MODE, phase_modes[p]);
         count = 0;
         while (count < PHASE_ITEMS) begin
            if (p == 2 && count >= PHASE_ITEMS / 2 && count < PHASE_ITEMS / 2 + 2) begin
               push_control(FEED_DRAIN, yuvrgb_pkg::MODE_PACKED);
            end
            px = random_pixels();
            push_pixels(px);
            count++;
            // planar 4:2:0 streams repeat each chroma pair for the second luma row
            if (phase_modes[p] == yuvrgb_pkg::MODE_PLANAR && $urandom_range(0, 3) != 0) begin
               twin = random_pixels();
               twin.chroma_blue = px.chroma_blue;
               twin.chroma_red = px.chroma_red;
               push_pixels(twin);
               count++;
            end
         end
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      wait (pixel_feed.size() == 0 && !start && !csr_valid);
      wait (rgb_expected.size() == 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0 && rgb_expected.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_NS);
      $display("FAILED: results differ");
      $finish;
   end

endmodule
